>>> rtl/ppds_pkg.sv
// Shared constants and types for the PWM period divider search unit.
`timescale 1ns / 1ps
`default_nettype none

package ppds_pkg;

  // Frequency clamp limits and reload range
  localparam logic [23:0] FREQ_MIN_HZ = 24'd1;
  localparam logic [23:0] FREQ_MAX_HZ = 24'd10000000;
  localparam logic [15:0] RELOAD_MAX  = 16'hFFFF;

  // Reload range plus two: divisor factor that gives the smallest prescaler
  localparam logic [16:0] SEARCH_MUL  = 17'h10001;

  // Configuration register indexes and reset values
  localparam logic        CFG_BUS_CLOCK   = 1'b0;
  localparam logic        CFG_BUS_DIVIDED = 1'b1;
  localparam logic [30:0] BUS_CLOCK_RESET = 31'd84000000;
  localparam logic        BUS_DIV_RESET   = 1'b1;

  // Operand widths of the shared divider
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W  = 41;

  // Divider result returned to the sequencer
  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

>>> rtl/ppds_div.sv
// Restoring divider, one quotient bit per cycle, shared by all three divisions.
`timescale 1ns / 1ps
`default_nettype none

module ppds_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [ppds_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [ppds_pkg::DIVISOR_W-1:0]   divisor,
  output ppds_pkg::div_res_t                    res
);

  localparam int CNT_W = $clog2(ppds_pkg::DIVIDEND_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ppds_pkg::DIVIDEND_W - 1);

  logic [ppds_pkg::DIVIDEND_W-1:0] rem_r, rem_nxt;
  logic [ppds_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [ppds_pkg::DIVISOR_W-1:0]  den_r;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            active_r, active_nxt;
  logic                            done_r, done_nxt;

  logic [ppds_pkg::DIVIDEND_W:0]   trial;
  logic [ppds_pkg::DIVIDEND_W:0]   diff;
  logic                            ge;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    trial = {rem_r, quo_r[ppds_pkg::DIVIDEND_W-1]};
    ge    = {{(ppds_pkg::DIVISOR_W-ppds_pkg::DIVIDEND_W-1){1'b0}}, trial} >= den_r;
    diff  = trial - den_r[ppds_pkg::DIVIDEND_W:0];
  end

  // Sequence the 32 steps
  always_comb begin
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      rem_nxt    = '0;
      quo_nxt    = dividend;
      cnt_nxt    = '0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      rem_nxt = ge ? diff[ppds_pkg::DIVIDEND_W-1:0] : trial[ppds_pkg::DIVIDEND_W-1:0];
      quo_nxt = {quo_r[ppds_pkg::DIVIDEND_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Datapath registers, divisor latched at start
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;

endmodule

`default_nettype wire

>>> rtl/pwm_period_divider_search_unit.sv
// Top level: prescaler and reload search for a requested PWM frequency.
`timescale 1ns / 1ps
`default_nettype none

// One request in, one result out. The requested frequency is clamped to
// 1..10000000 Hz and the timer clock is the bus clock, doubled when the bus
// divider flag is set. The block takes the smallest prescaler as
// clock / (65537 * f), then the reload from clock / (f * (prescaler + 1)),
// then the actual frequency from clock / ((prescaler + 1) * (reload + 1)).
// All three quotients come from one shared restoring divider that produces
// one quotient bit per cycle, fed by one small multiplier. The last division
// is skipped when the reload quotient is 1 or less. in_stall is high while a
// request is in work or its result waits for the output register, so the
// next request can be taken in the same cycle in which result valid rises.
// Configuration may be written only while the block is idle.
module pwm_period_divider_search_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [30:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_requested_hz,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_prescaler,
  output logic [15:0]      out_reload,
  output logic [31:0]      out_actual_hz
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_L1   = 4'd1;
  localparam logic [3:0] S_W1   = 4'd2;
  localparam logic [3:0] S_L2   = 4'd3;
  localparam logic [3:0] S_W2   = 4'd4;
  localparam logic [3:0] S_L3   = 4'd5;
  localparam logic [3:0] S_W3   = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [30:0] bus_clock_r;
  logic        bus_div_r;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] clk_r, clk_nxt;
  logic [23:0] f_r, f_nxt;
  logic [15:0] p_r, p_nxt;
  logic [16:0] q_r, q_nxt;
  logic [15:0] psc_r, psc_nxt;
  logic [15:0] arr_r, arr_nxt;
  logic [31:0] act_r, act_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_psc_r, out_psc_nxt;
  logic [15:0] out_arr_r, out_arr_nxt;
  logic [31:0] out_act_r, out_act_nxt;

  logic        in_fire;
  logic        out_free;
  logic [23:0] mul_a;
  logic [16:0] mul_b;
  logic [16:0] p_inc;
  logic [ppds_pkg::DIVISOR_W-1:0] prod;
  logic        div_start;
  ppds_pkg::div_res_t div_res;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign p_inc    = {1'b0, p_r} + 17'd1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_clock_r <= ppds_pkg::BUS_CLOCK_RESET;
      bus_div_r   <= ppds_pkg::BUS_DIV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ppds_pkg::CFG_BUS_CLOCK:   bus_clock_r <= cfg_wdata;
        ppds_pkg::CFG_BUS_DIVIDED: bus_div_r   <= cfg_wdata[0];
        default:                   bus_clock_r <= bus_clock_r;
      endcase
    end
  end

  // Select multiplier operands for the divisor of the next division
  always_comb begin
    case (state_r)
      S_L1: begin
        mul_a = f_r;
        mul_b = ppds_pkg::SEARCH_MUL;
      end
      S_L2: begin
        mul_a = f_r;
        mul_b = p_inc;
      end
      default: begin
        mul_a = {7'd0, q_r};
        mul_b = p_inc;
      end
    endcase
    prod      = ppds_pkg::DIVISOR_W'(mul_a) * ppds_pkg::DIVISOR_W'(mul_b);
    div_start = (state_r == S_L1) || (state_r == S_L2) || (state_r == S_L3);
  end

  ppds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (clk_r),
    .divisor  (prod),
    .res      (div_res)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clk_nxt       = clk_r;
    f_nxt         = f_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    psc_nxt       = psc_r;
    arr_nxt       = arr_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_psc_nxt   = out_psc_r;
    out_arr_nxt   = out_arr_r;
    out_act_nxt   = out_act_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Clamp the request and form the timer clock
          if (in_requested_hz == 32'd0) begin
            f_nxt = ppds_pkg::FREQ_MIN_HZ;
          end else if (in_requested_hz > {8'd0, ppds_pkg::FREQ_MAX_HZ}) begin
            f_nxt = ppds_pkg::FREQ_MAX_HZ;
          end else begin
            f_nxt = in_requested_hz[23:0];
          end
          clk_nxt   = bus_div_r ? {bus_clock_r, 1'b0} : {1'b0, bus_clock_r};
          state_nxt = S_L1;
        end
      end
      S_L1: state_nxt = S_W1;
      S_W1: begin
        if (div_res.done) begin
          p_nxt     = div_res.quo[15:0];
          state_nxt = S_L2;
        end
      end
      S_L2: state_nxt = S_W2;
      S_W2: begin
        if (div_res.done) begin
          if (div_res.quo <= 32'd1) begin
            // Quotient too small: no division left, clock comes out as is
            psc_nxt   = '0;
            arr_nxt   = '0;
            act_nxt   = clk_r;
            state_nxt = S_OUT;
          end else begin
            q_nxt     = div_res.quo[16:0];
            psc_nxt   = p_r;
            arr_nxt   = div_res.quo[15:0] - 16'd1;
            state_nxt = S_L3;
          end
        end
      end
      S_L3: state_nxt = S_W3;
      S_W3: begin
        if (div_res.done) begin
          act_nxt   = div_res.quo;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_psc_nxt   = psc_r;
          out_arr_nxt   = arr_r;
          out_act_nxt   = act_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    clk_r     <= clk_nxt;
    f_r       <= f_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    psc_r     <= psc_nxt;
    arr_r     <= arr_nxt;
    act_r     <= act_nxt;
    out_psc_r <= out_psc_nxt;
    out_arr_r <= out_arr_nxt;
    out_act_r <= out_act_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_prescaler = out_psc_r;
  assign out_reload    = out_arr_r;
  assign out_actual_hz = out_act_r;

endmodule

`default_nettype wire

>>> tb/tb_pwm_period_divider_search_unit.sv
// Testbench for the PWM period divider search unit, with a built-in result predictor.
`timescale 1ns / 1ps

module tb_pwm_period_divider_search_unit;

  // One timer setting as the block reports it
  typedef struct {
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [31:0] actual_hz;
  } timer_setting_t;

  localparam int LONG_HOLD_CYCLES = 600;
  localparam int LONG_HOLD_AFTER  = 150;
  localparam int SETTLE_CYCLES    = 150;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_ITEMS      = 100;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = ppds_pkg::CFG_BUS_CLOCK;
  logic [30:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_requested_hz = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_prescaler;
  logic [15:0] out_reload;
  logic [31:0] out_actual_hz;

  // Mirror of the configuration registers
  logic [30:0] bus_clock_hz = ppds_pkg::BUS_CLOCK_RESET;
  logic        bus_divided = ppds_pkg::BUS_DIV_RESET;

  logic [31:0]    freq_requests[$];
  timer_setting_t pending_settings[$];
  int             requests_queued = 0;
  int             requests_taken = 0;
  int             settings_seen = 0;
  int             mismatch_count = 0;
  logic           in_taken = 1'b0;
  logic           burst_mode = 1'b0;
  int             send_gap = 0;
  int             stall_left = 0;
  int             hold_left = 0;
  logic           hold_done = 1'b0;

  pwm_period_divider_search_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_requested_hz (in_requested_hz),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_prescaler   (out_prescaler),
    .out_reload      (out_reload),
    .out_actual_hz   (out_actual_hz)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Expected prescaler, reload and actual frequency for one request
  function automatic timer_setting_t calc_timer_setting(logic [31:0] requested);
    timer_setting_t res;
    logic [63:0] freq;
    logic [63:0] timer_clk;
    logic [63:0] psc;
    logic [63:0] quo;
    logic [63:0] arr;
    freq = {32'd0, requested};
    if (freq < 64'(ppds_pkg::FREQ_MIN_HZ)) freq = 64'(ppds_pkg::FREQ_MIN_HZ);
    else if (freq > 64'(ppds_pkg::FREQ_MAX_HZ)) freq = 64'(ppds_pkg::FREQ_MAX_HZ);
    timer_clk = {33'd0, bus_clock_hz};
    if (bus_divided) timer_clk = timer_clk << 1;
    psc = timer_clk / (freq * 64'(ppds_pkg::SEARCH_MUL));
    if (psc > 64'(ppds_pkg::RELOAD_MAX)) psc = 64'(ppds_pkg::RELOAD_MAX);
    quo = timer_clk / (freq * (psc + 64'd1));
    // Quotient too small: fall back to the undivided timer clock
    if (quo <= 64'd1) begin
      psc = 64'd0;
      arr = 64'd0;
    end else begin
      arr = quo - 64'd1;
      if (arr > 64'(ppds_pkg::RELOAD_MAX)) arr = 64'(ppds_pkg::RELOAD_MAX);
    end
    res.prescaler = psc[15:0];
    res.reload    = arr[15:0];
    res.actual_hz = 32'(timer_clk / ((psc + 64'd1) * (arr + 64'd1)));
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(20, 4);
    return $urandom_range(200, 50);
  endfunction

  function automatic logic [31:0] pick_request();
    case ($urandom_range(9, 0))
      0, 1, 2: return $urandom();
      3, 4, 5: return $urandom_range(10000000, 1);
      6, 7:    return $urandom_range(2000, 1);
      8:       return $urandom_range(10000010, 9999990);
      default: return $urandom_range(3, 0);
    endcase
  endfunction

  function automatic logic [30:0] pick_bus_clock();
    case ($urandom_range(3, 0))
      0:       return 31'($urandom_range(200, 1));
      1:       return 31'($urandom());
      2:       return 31'($urandom_range(200000000, 1000000));
      default: return 31'h7FFFFFFF;
    endcase
  endfunction

  // Monitor: mirror config writes, predict accepted beats, check result beats
  always @(posedge clk) begin
    timer_setting_t exp_set;
    in_taken <= in_valid && !in_stall;
    if (!rst_n) begin
      bus_clock_hz <= ppds_pkg::BUS_CLOCK_RESET;
      bus_divided  <= ppds_pkg::BUS_DIV_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppds_pkg::CFG_BUS_CLOCK:   bus_clock_hz <= cfg_wdata;
          ppds_pkg::CFG_BUS_DIVIDED: bus_divided  <= cfg_wdata[0];
          default:                   bus_clock_hz <= bus_clock_hz;
        endcase
      end
      if (in_valid && !in_stall) begin
        pending_settings.push_back(calc_timer_setting(in_requested_hz));
        requests_taken++;
      end
      if (out_valid && !out_stall) begin
        settings_seen++;
        if (pending_settings.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatch_count++;
        end else begin
          exp_set = pending_settings.pop_front();
          if (out_prescaler !== exp_set.prescaler) begin
            $error("prescaler: expected %0d, actual %0d", exp_set.prescaler, out_prescaler);
            mismatch_count++;
          end
          if (out_reload !== exp_set.reload) begin
            $error("reload: expected %0d, actual %0d", exp_set.reload, out_reload);
            mismatch_count++;
          end
          if (out_actual_hz !== exp_set.actual_hz) begin
            $error("actual_hz: expected %0d, actual %0d", exp_set.actual_hz, out_actual_hz);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Driver: offer the next request once the current beat is taken
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (freq_requests.size() != 0) begin
        in_valid        <= 1'b1;
        in_requested_hz <= freq_requests.pop_front();
        send_gap        <= burst_mode ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back up the input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && settings_seen >= LONG_HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (burst_mode) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall  <= 1'b0;
    end
  end

  task automatic queue_request(input logic [31:0] hz);
    freq_requests.push_back(hz);
    requests_queued++;
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timer_clock(input logic [30:0] bus_hz, input logic div);
    write_reg(ppds_pkg::CFG_BUS_CLOCK, bus_hz);
    write_reg(ppds_pkg::CFG_BUS_DIVIDED, {30'd0, div});
  endtask

  // Wait until every request is taken and every result checked
  task automatic drain_results();
    @(negedge clk);
    while (requests_taken != requests_queued || pending_settings.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: clamp edges and extremes at the reset clock
    queue_request(32'd0);
    queue_request(32'd1);
    queue_request(32'd2);
    queue_request(32'd1000);
    queue_request(32'd9999999);
    queue_request(32'd10000000);
    queue_request(32'd10000001);
    queue_request(32'h80000000);
    queue_request(32'hFFFFFFFF);
    queue_request(32'd21000);
    drain_results();

    // Largest timer clock: prescaler search at its top
    set_timer_clock(31'h7FFFFFFF, 1'b1);
    queue_request(32'd0);
    queue_request(32'd1);
    queue_request(32'd2);
    queue_request(32'd65535);
    queue_request(32'd10000000);
    drain_results();

    // Smallest clock: quotient too small for any reload
    set_timer_clock(31'd1, 1'b0);
    queue_request(32'd1);
    queue_request(32'd2);
    queue_request(32'hFFFFFFFF);
    drain_results();

    // Zero bus clock
    set_timer_clock(31'd0, 1'b1);
    queue_request(32'd1);
    queue_request(32'd7);
    queue_request(32'hFFFFFFFF);
    drain_results();

    // Random phases, each under its own clock setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      burst_mode <= (ph % 3 == 2);
      case (ph)
        0:       set_timer_clock(31'h7FFFFFFF, 1'b0);
        1:       set_timer_clock(31'd1, 1'b1);
        2:       set_timer_clock(31'd84000000, 1'b0);
        default: set_timer_clock(pick_bus_clock(), 1'($urandom_range(1, 0)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) queue_request(pick_request());
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_settings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> pwm_period_divider_search_unit.f
rtl/ppds_pkg.sv
rtl/ppds_div.sv
rtl/pwm_period_divider_search_unit.sv
tb/tb_pwm_period_divider_search_unit.sv
